[src/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and fixed-point helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = DATA_W + 2;
    localparam int WIDE_W    = DATA_W + 3;
    localparam int LIM_W     = DATA_W - 1;
    localparam int IDX_W     = 3;
    localparam int HALF_SHIFT = DATA_W + 1;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [IDX_W-1:0] REG_P_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_I_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_D_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd4;
    localparam logic [IDX_W-1:0] REG_INV_PER  = 3'd5;

    localparam logic signed [DATA_W-1:0] RST_P_GAIN  = 32'sd154010;
    localparam logic signed [DATA_W-1:0] RST_I_GAIN  = 32'sd3277;
    localparam logic signed [DATA_W-1:0] RST_D_GAIN  = 32'sd5243;
    localparam logic [LIM_W-1:0]         RST_LIMIT   = 31'd52428800;
    localparam logic [DATA_W-1:0]        RST_PERIOD  = 32'd17179869;
    localparam logic [LIM_W-1:0]         RST_INV_PER = 31'd16384000;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_INT,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D1,
        ST_TSAT,
        ST_MUL_D2,
        ST_SUM,
        ST_CLR
    } state_t;

    typedef enum logic [2:0] {
        MUL_SEL_INT,
        MUL_SEL_P,
        MUL_SEL_I,
        MUL_SEL_D1,
        MUL_SEL_D2
    } mul_sel_t;

    typedef struct packed {
        logic     s_ready;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_integral;
        logic     ld_acc_p;
        logic     add_acc_i;
        logic     ld_t;
        logic     ld_out;
        logic     zero_out;
    } ctrl_t;

    // Q16.16 product scaled back with floor rounding, then saturated to 32 bits.
    function automatic logic signed [DATA_W-1:0] q_sat(input logic signed [PROD_W-1:0] prod);
        logic hi_same;
        hi_same = (prod[PROD_W-1:FRAC_BITS+DATA_W-1]
                   == {(PROD_W-FRAC_BITS-DATA_W+1){prod[PROD_W-1]}});
        if (hi_same) begin
            q_sat = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end else if (prod[PROD_W-1]) begin
            q_sat = Q_MIN;
        end else begin
            q_sat = Q_MAX;
        end
    endfunction

    // Symmetric clamp to plus or minus the limit.
    function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [WIDE_W-1:0] v,
                                                           input logic [LIM_W-1:0] lim);
        logic signed [WIDE_W-1:0] lim_p;
        logic signed [WIDE_W-1:0] lim_n;
        lim_p = $signed({{(WIDE_W-LIM_W){1'b0}}, lim});
        lim_n = -lim_p;
        if (v > lim_p) begin
            clamp_lim = lim_p[DATA_W-1:0];
        end else if (v < lim_n) begin
            clamp_lim = lim_n[DATA_W-1:0];
        end else begin
            clamp_lim = v[DATA_W-1:0];
        end
    endfunction

endpackage

[src/pidaw_mul.sv]
// ----------------------------------------------------------------------------
// pidaw_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidaw_mul (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [pidaw_pkg::OPND_W-1:0]    op_a,
    input  logic signed [pidaw_pkg::OPND_W-1:0]    op_b,
    output logic signed [pidaw_pkg::PROD_W-1:0]    prod_reg
);

    logic signed [pidaw_pkg::PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

[src/pidaw_ctrl.sv]
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer that steps one sample through the shared multiplier.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_opcode,
    input  logic              out_free,
    output pidaw_pkg::ctrl_t  ctrl
);

    pidaw_pkg::state_t state_reg;
    pidaw_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pidaw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.mul_sel = pidaw_pkg::MUL_SEL_INT;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE: begin
                ctrl.s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == pidaw_pkg::OP_CLEAR) begin
                        state_next = pidaw_pkg::ST_CLR;
                    end else begin
                        state_next = pidaw_pkg::ST_MUL_INT;
                    end
                end
            end
            pidaw_pkg::ST_MUL_INT: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = pidaw_pkg::MUL_SEL_INT;
                state_next   = pidaw_pkg::ST_MUL_P;
            end
            pidaw_pkg::ST_MUL_P: begin
                ctrl.mul_en       = 1'b1;
                ctrl.mul_sel      = pidaw_pkg::MUL_SEL_P;
                ctrl.upd_integral = 1'b1;
                state_next        = pidaw_pkg::ST_MUL_I;
            end
            pidaw_pkg::ST_MUL_I: begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = pidaw_pkg::MUL_SEL_I;
                ctrl.ld_acc_p = 1'b1;
                state_next    = pidaw_pkg::ST_MUL_D1;
            end
            pidaw_pkg::ST_MUL_D1: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = pidaw_pkg::MUL_SEL_D1;
                ctrl.add_acc_i = 1'b1;
                state_next     = pidaw_pkg::ST_TSAT;
            end
            pidaw_pkg::ST_TSAT: begin
                ctrl.ld_t  = 1'b1;
                state_next = pidaw_pkg::ST_MUL_D2;
            end
            pidaw_pkg::ST_MUL_D2: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = pidaw_pkg::MUL_SEL_D2;
                state_next   = pidaw_pkg::ST_SUM;
            end
            pidaw_pkg::ST_SUM: begin
                if (out_free) begin
                    ctrl.ld_out = 1'b1;
                    state_next  = pidaw_pkg::ST_IDLE;
                end
            end
            pidaw_pkg::ST_CLR: begin
                if (out_free) begin
                    ctrl.ld_out   = 1'b1;
                    ctrl.zero_out = 1'b1;
                    state_next    = pidaw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pidaw_pkg::ST_IDLE;
            end
        endcase
    end

    // The sequencer takes no new beat while one is in progress.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && ctrl.s_ready) |=> !ctrl.s_ready)
        else $error("sequencer ready right after accepting a beat");

    // A result is only written when the output register can take it.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ld_out |-> out_free)
        else $error("result loaded over a pending output");

endmodule

[src/pid_controller_antiwindup_unit.sv]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// PID controller with trapezoidal integral and anti-windup clamp, Q16.16.
// ----------------------------------------------------------------------------
// A compute beat steps through MUL_INT, MUL_P, MUL_I, MUL_D1, TSAT, MUL_D2 and
// SUM before its result is loaded, a clear beat through CLR. No new beat is
// taken before that, since the shared 33x33 multiplier runs five products
// per sample. A result that is not taken holds the sequencer in its last step.
// Synchronous active-low reset clears the integral, the previous error and the
// handshake state, and loads the gain, limit and period registers with defaults.
module pid_controller_antiwindup_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [pidaw_pkg::IDX_W-1:0]            cfg_index,
    input  logic [pidaw_pkg::DATA_W-1:0]           cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic signed [pidaw_pkg::DATA_W-1:0]    s_error_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pidaw_pkg::DATA_W-1:0]    m_control_out
);

    localparam int DW = pidaw_pkg::DATA_W;
    localparam int OW = pidaw_pkg::OPND_W;
    localparam int PW = pidaw_pkg::PROD_W;
    localparam int AW = pidaw_pkg::ACC_W;
    localparam int WW = pidaw_pkg::WIDE_W;
    localparam int LW = pidaw_pkg::LIM_W;
    localparam int HS = pidaw_pkg::HALF_SHIFT;

    logic signed [DW-1:0] p_gain_reg;
    logic signed [DW-1:0] i_gain_reg;
    logic signed [DW-1:0] d_gain_reg;
    logic [LW-1:0]        limit_reg;
    logic [DW-1:0]        period_reg;
    logic [LW-1:0]        inv_period_reg;

    logic signed [DW-1:0] e_reg;
    logic signed [OW-1:0] sum_reg;
    logic signed [OW-1:0] diff_reg;
    logic signed [DW-1:0] integral_reg;
    logic signed [DW-1:0] integral_next;
    logic signed [DW-1:0] last_error_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [DW-1:0] t_reg;
    logic signed [DW-1:0] out_reg;
    logic signed [DW-1:0] out_next;
    logic                 m_valid_reg;

    logic                 out_free;
    logic                 step_beat;
    logic                 clear_beat;
    logic signed [OW-1:0] op_a;
    logic signed [OW-1:0] op_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [DW-1:0] prod_q;
    logic signed [OW-1:0] inc;
    logic                 inc_round;
    logic signed [WW-1:0] out_sum;

    pidaw_pkg::ctrl_t ctrl;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = ctrl.s_ready;
    assign step_beat  = s_valid && s_ready && (s_opcode == pidaw_pkg::OP_STEP);
    assign clear_beat = s_valid && s_ready && (s_opcode == pidaw_pkg::OP_CLEAR);
    assign m_valid       = m_valid_reg;
    assign m_control_out = out_reg;

    pidaw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    always_comb begin
        unique case (ctrl.mul_sel)
            pidaw_pkg::MUL_SEL_INT: begin
                op_a = sum_reg;
                op_b = $signed({1'b0, period_reg});
            end
            pidaw_pkg::MUL_SEL_P: begin
                op_a = {p_gain_reg[DW-1], p_gain_reg};
                op_b = {e_reg[DW-1], e_reg};
            end
            pidaw_pkg::MUL_SEL_I: begin
                op_a = {i_gain_reg[DW-1], i_gain_reg};
                op_b = {integral_reg[DW-1], integral_reg};
            end
            pidaw_pkg::MUL_SEL_D1: begin
                op_a = {d_gain_reg[DW-1], d_gain_reg};
                op_b = diff_reg;
            end
            pidaw_pkg::MUL_SEL_D2: begin
                op_a = {t_reg[DW-1], t_reg};
                op_b = $signed({{(OW-LW){1'b0}}, inv_period_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    pidaw_mul u_mul (
        .aclk     (aclk),
        .en       (ctrl.mul_en),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    assign prod_q = pidaw_pkg::q_sat(prod_reg);

    // Half-period increment, rounded toward zero.
    assign inc_round = prod_reg[PW-1] && (|prod_reg[HS-1:0]);
    assign inc       = $signed(prod_reg[PW-1:HS]) + $signed({{(OW-1){1'b0}}, inc_round});

    assign integral_next = pidaw_pkg::clamp_lim(
        $signed({{(WW-DW){integral_reg[DW-1]}}, integral_reg})
        + $signed({{(WW-OW){inc[OW-1]}}, inc}), limit_reg);

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.ld_acc_p) begin
            acc_next = $signed({{(AW-DW){prod_q[DW-1]}}, prod_q});
        end else if (ctrl.add_acc_i) begin
            acc_next = acc_reg + $signed({{(AW-DW){prod_q[DW-1]}}, prod_q});
        end
    end

    assign out_sum  = $signed({acc_reg[AW-1], acc_reg})
                    + $signed({{(WW-DW){prod_q[DW-1]}}, prod_q});
    assign out_next = ctrl.zero_out ? '0 : pidaw_pkg::clamp_lim(out_sum, limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg     <= pidaw_pkg::RST_P_GAIN;
            i_gain_reg     <= pidaw_pkg::RST_I_GAIN;
            d_gain_reg     <= pidaw_pkg::RST_D_GAIN;
            limit_reg      <= pidaw_pkg::RST_LIMIT;
            period_reg     <= pidaw_pkg::RST_PERIOD;
            inv_period_reg <= pidaw_pkg::RST_INV_PER;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pidaw_pkg::REG_P_GAIN:  p_gain_reg     <= cfg_wdata;
                pidaw_pkg::REG_I_GAIN:  i_gain_reg     <= cfg_wdata;
                pidaw_pkg::REG_D_GAIN:  d_gain_reg     <= cfg_wdata;
                pidaw_pkg::REG_LIMIT:   limit_reg      <= cfg_wdata[LW-1:0];
                pidaw_pkg::REG_PERIOD:  period_reg     <= cfg_wdata;
                pidaw_pkg::REG_INV_PER: inv_period_reg <= cfg_wdata[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg   <= '0;
            last_error_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clear_beat) begin
                integral_reg   <= '0;
                last_error_reg <= '0;
            end else begin
                if (ctrl.upd_integral) begin
                    integral_reg <= integral_next;
                end
                if (ctrl.ld_out && !ctrl.zero_out) begin
                    last_error_reg <= e_reg;
                end
            end
            if (ctrl.ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_beat) begin
            e_reg    <= s_error_in;
            sum_reg  <= $signed({s_error_in[DW-1], s_error_in})
                      + $signed({last_error_reg[DW-1], last_error_reg});
            diff_reg <= $signed({s_error_in[DW-1], s_error_in})
                      - $signed({last_error_reg[DW-1], last_error_reg});
        end
        acc_reg <= acc_next;
        if (ctrl.ld_t) begin
            t_reg <= prod_q;
        end
        if (ctrl.ld_out) begin
            out_reg <= out_next;
        end
    end

    // A clear beat leaves the integral and the previous error at zero.
    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_beat |=> (integral_reg == '0 && last_error_reg == '0))
        else $error("state not cleared after a clear beat");

    // A taken result is not shown again unless a new one was loaded.
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !ctrl.ld_out) |=> !m_valid)
        else $error("result beat repeated");

    // Each result follows an accepted beat, so no load happens while ready.
    a_load_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ld_out |-> !s_ready)
        else $error("result loaded while idle");

endmodule

[verif/pidaw_drive_checker.sv]
// ----------------------------------------------------------------------------
// pidaw_drive_checker
// Watches the register port and both beat channels of the PID controller,
// predicts each drive value from its own copy of the gains, limit, period and
// loop state, and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module pidaw_drive_checker
    import pidaw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_opcode,
    input  logic signed [DATA_W-1:0] s_error_in,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_control_out,
    output int                       mismatches,
    output int                       pending,
    output int                       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AREA_W = 3 * DATA_W;

    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic [LIM_W-1:0]         limit_q;
    logic [DATA_W-1:0]        period_q;
    logic [LIM_W-1:0]         inv_period_q;
    logic signed [DATA_W-1:0] integral_q;
    logic signed [DATA_W-1:0] prev_error_q;
    logic signed [DATA_W-1:0] drive_q[$];

    function automatic longint sat_word(input longint v);
        if (v > longint'(Q_MAX)) return longint'(Q_MAX);
        if (v < longint'(Q_MIN)) return longint'(Q_MIN);
        return v;
    endfunction

    function automatic longint clamp_to_limit(input longint v);
        longint bound;
        bound = longint'(limit_q);
        if (v > bound) return bound;
        if (v < -bound) return -bound;
        return v;
    endfunction

    function automatic longint scale_mul(input longint a, input longint b);
        return sat_word((a * b) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] predict_drive(
        input logic op, input logic signed [DATA_W-1:0] err);
        longint      e;
        longint      prev;
        longint      s;
        longint      inc;
        longint      p;
        longint      i;
        longint      t;
        longint      d;
        logic [AREA_W-1:0] mag;
        logic [AREA_W-1:0] area;
        if (op == OP_CLEAR) begin
            integral_q   = '0;
            prev_error_q = '0;
            return '0;
        end
        e    = err;
        prev = prev_error_q;
        s    = e + prev;
        mag  = (s < 0) ? -s : s;
        area = mag * AREA_W'(period_q);
        inc  = longint'(area >> HALF_SHIFT);
        if (s < 0) inc = -inc;
        integral_q = DATA_W'(clamp_to_limit(longint'(integral_q) + inc));
        p = scale_mul(kp, e);
        i = scale_mul(ki, integral_q);
        t = scale_mul(kd, e - prev);
        d = scale_mul(t, longint'(inv_period_q));
        prev_error_q = err;
        return DATA_W'(clamp_to_limit(p + i + d));
    endfunction

    task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] want,
                                   input logic signed [DATA_W-1:0] got);
        $display("%0t ns: %s: control_out expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        logic signed [DATA_W-1:0] want;
        if (!aresetn) begin
            kp           = RST_P_GAIN;
            ki           = RST_I_GAIN;
            kd           = RST_D_GAIN;
            limit_q      = RST_LIMIT;
            period_q     = RST_PERIOD;
            inv_period_q = RST_INV_PER;
            integral_q   = '0;
            prev_error_q = '0;
            drive_q.delete();
            mismatches   = 0;
            checked      = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_P_GAIN:  kp = cfg_wdata;
                    REG_I_GAIN:  ki = cfg_wdata;
                    REG_D_GAIN:  kd = cfg_wdata;
                    REG_LIMIT:   limit_q = cfg_wdata[LIM_W-1:0];
                    REG_PERIOD:  period_q = cfg_wdata;
                    REG_INV_PER: inv_period_q = cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("result beat with no input outstanding", '0, m_control_out);
                end else begin
                    want = drive_q.pop_front();
                    if (m_control_out !== want) begin
                        report_mismatch("wrong drive value", want, m_control_out);
                    end
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                drive_q.push_back(predict_drive(s_opcode, s_error_in));
            end
        end
        pending = drive_q.size();
    end

endmodule

[verif/pid_controller_antiwindup_unit_tb.sv]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit_tb
// Drives error samples and clear beats into the PID controller under a series
// of register settings, with random gaps on the input and random stalls on
// the output, and leaves the checking of every drive value to the checker.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit_tb
    import pidaw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [IDX_W-1:0]         cfg_index;
    logic [DATA_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_opcode;
    logic signed [DATA_W-1:0] s_error_in;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_control_out;

    int mismatches;
    int pending;
    int checked;
    int idle_cycles;
    int beats_sent;
    int clears_sent;
    int settings_used;
    bit steady;

    pid_controller_antiwindup_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_error_in    (s_error_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_control_out (m_control_out)
    );

    pidaw_drive_checker drive_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_error_in    (s_error_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_control_out (m_control_out),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] gen_error();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        if (roll < 60) return $signed($urandom) >>> 4;
        if (roll < 72) begin
            case ($urandom_range(0, 4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 32'sd0;
                3: return 32'sd1;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        if ($urandom_range(0, 1) == 0) begin
            return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        end
        return $urandom;
    endfunction

    task automatic send_beat(input logic op, input logic signed [DATA_W-1:0] err);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_error_in <= err;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_sent++;
        if (op == OP_CLEAR) clears_sent++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] kp, ki, kd, lim, per, inv);
        write_reg(REG_P_GAIN, kp);
        write_reg(REG_I_GAIN, ki);
        write_reg(REG_D_GAIN, kd);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_PERIOD, per);
        write_reg(REG_INV_PER, inv);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Lets the controller finish every outstanding beat before registers change.
    task automatic drain();
        s_valid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        int                       sent;
        int                       burst;
        bit                       neg;
        logic signed [DATA_W-1:0] e;
        sent = 0;
        while (sent < count) begin
            steady = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 15) == 0) begin
                send_beat(OP_CLEAR, $urandom);
                sent++;
            end else begin
                // Runs of one sign wind the integral up against its clamp.
                burst = $urandom_range(1, 16);
                neg   = $urandom_range(0, 1);
                repeat (burst) begin
                    e = gen_error();
                    if ($urandom_range(0, 3) != 0 && e[DATA_W-1] != neg) e = ~e;
                    send_beat(OP_STEP, e);
                    sent++;
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (m_ready) begin
                m_ready <= 1'b0;
                hold = pick_gap();
            end else begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 12);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_opcode      = OP_STEP;
        s_error_in    = '0;
        steady        = 1'b0;
        beats_sent    = 0;
        clears_sent   = 0;
        settings_used = 1;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_beat(OP_STEP, 32'sd0);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_STEP, Q_MIN);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_CLEAR, $urandom);
        send_beat(OP_STEP, 32'sd1);
        send_beat(OP_STEP, -32'sd1);
        send_beat(OP_STEP, 32'sd65536);
        send_beat(OP_STEP, -32'sd65536);
        send_beat(OP_CLEAR, 32'sd0);
        run_random(300);
        drain();

        apply_setting(Q_MAX, Q_MIN, Q_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_STEP, Q_MIN);
        send_beat(OP_STEP, Q_MIN);
        send_beat(OP_CLEAR, Q_MAX);
        send_beat(OP_STEP, 32'sd0);
        run_random(150);
        drain();

        apply_setting(rand_gain(), rand_gain(), rand_gain(), '0, $urandom, $urandom);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_STEP, Q_MIN);
        send_beat(OP_STEP, 32'sd12345);
        run_random(60);
        drain();

        apply_setting(rand_gain(), rand_gain(), rand_gain(), {1'b0, RST_LIMIT}, '0, '0);
        send_beat(OP_STEP, Q_MAX);
        send_beat(OP_STEP, Q_MIN);
        run_random(60);
        drain();

        repeat (6) begin
            apply_setting(rand_gain(), rand_gain(), rand_gain(),
                          $urandom_range(0, 32'h0FFF_FFFF) | ($urandom & 32'h8000_0000),
                          $urandom, $urandom);
            run_random(130);
            drain();
        end

        apply_setting(Q_MIN, Q_MAX, Q_MIN, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        run_random(100);
        drain();

        $display("Sent %0d beats (%0d clears) under %0d register settings; %0d results compared.",
                 beats_sent, clears_sent, settings_used, checked);
        $display("Settings took in reset values, full-scale gains, a zero limit, a zero period.");
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
